// ----- hw/rtl/gpiop_pkg.sv -----
`default_nettype none

package gpiop_pkg;

  localparam int NUM_PINS = 30;
  localparam int PINS_PER_BANK = 8;
  localparam int NUM_BANKS = 4;
  localparam int WORD_W = 32;
  localparam int BANK_W = 2;

  localparam logic [NUM_PINS-1:0] PIN_MASK = '1;

  localparam logic [1:0] KIND_READ = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  localparam logic [3:0] REG_IN = 4'd0;
  localparam logic [3:0] REG_OUT = 4'd1;
  localparam logic [3:0] REG_OUT_SET = 4'd2;
  localparam logic [3:0] REG_OUT_CLR = 4'd3;
  localparam logic [3:0] REG_OUT_XOR = 4'd4;
  localparam logic [3:0] REG_OE = 4'd5;
  localparam logic [3:0] REG_OE_SET = 4'd6;
  localparam logic [3:0] REG_OE_CLR = 4'd7;
  localparam logic [3:0] REG_OE_XOR = 4'd8;
  localparam logic [3:0] REG_INTR = 4'd9;
  localparam logic [3:0] REG_INTE = 4'd10;
  localparam logic [3:0] REG_INTE_SET = 4'd11;
  localparam logic [3:0] REG_INTE_CLR = 4'd12;
  localparam logic [3:0] REG_INTS = 4'd13;

  localparam int BIT_LEVEL_LOW = 0;
  localparam int BIT_LEVEL_HIGH = 1;
  localparam int BIT_EDGE_FALL = 2;
  localparam int BIT_EDGE_RISE = 3;
  localparam int BITS_PER_PIN = 4;

  typedef logic [NUM_BANKS-1:0][WORD_W-1:0] bank_words_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [3:0]          reg_select;
    logic [BANK_W-1:0]   bank_index;
    logic [WORD_W-1:0]   write_data;
    logic [NUM_PINS-1:0] pin_levels;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]   read_data;
    logic [NUM_PINS-1:0] pin_out;
    logic [NUM_PINS-1:0] pin_oe;
    logic                irq;
  } rsp_t;

  // Raw interrupt words of all banks, four bits per pin.
  function automatic bank_words_t raw_banks(input logic [NUM_PINS-1:0] levels,
                                            input logic [NUM_PINS-1:0] fall,
                                            input logic [NUM_PINS-1:0] rise);
    bank_words_t v;
    int p;
    int s;
    v = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      for (int i = 0; i < PINS_PER_BANK; i++) begin
        p = b * PINS_PER_BANK + i;
        s = BITS_PER_PIN * i;
        if (p < NUM_PINS) begin
          v[b][s + BIT_LEVEL_LOW] = ~levels[p];
          v[b][s + BIT_LEVEL_HIGH] = levels[p];
          v[b][s + BIT_EDGE_FALL] = fall[p];
          v[b][s + BIT_EDGE_RISE] = rise[p];
        end
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gpiop_regfile.sv -----
`default_nettype none

module gpiop_regfile (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire gpiop_pkg::req_t req,
  output gpiop_pkg::rsp_t      rsp
);

  logic [gpiop_pkg::NUM_PINS-1:0] out_mask_r, out_mask_nxt;
  logic [gpiop_pkg::NUM_PINS-1:0] oe_mask_r, oe_mask_nxt;
  logic [gpiop_pkg::NUM_PINS-1:0] levels_r, levels_nxt;
  logic [gpiop_pkg::NUM_PINS-1:0] fall_r, fall_nxt;
  logic [gpiop_pkg::NUM_PINS-1:0] rise_r, rise_nxt;
  logic [gpiop_pkg::NUM_BANKS-1:0][gpiop_pkg::WORD_W-1:0] inte_r, inte_nxt;

  logic [gpiop_pkg::NUM_PINS-1:0] wmask;
  logic [gpiop_pkg::NUM_PINS-1:0] fall_clr;
  logic [gpiop_pkg::NUM_PINS-1:0] rise_clr;
  gpiop_pkg::bank_words_t         raw_now;
  gpiop_pkg::bank_words_t         raw_nxt;
  logic [gpiop_pkg::WORD_W-1:0]   read_data;
  logic [gpiop_pkg::NUM_BANKS-1:0] bank_hit;

  assign wmask = req.write_data[gpiop_pkg::NUM_PINS-1:0] & gpiop_pkg::PIN_MASK;

  // A write of one to an edge bit of the selected bank clears that latch.
  always_comb begin
    fall_clr = '0;
    rise_clr = '0;
    for (int p = 0; p < gpiop_pkg::NUM_PINS; p++) begin
      if (req.bank_index == gpiop_pkg::BANK_W'(p / gpiop_pkg::PINS_PER_BANK)) begin
        fall_clr[p] = req.write_data[gpiop_pkg::BITS_PER_PIN * (p % gpiop_pkg::PINS_PER_BANK)
                                     + gpiop_pkg::BIT_EDGE_FALL];
        rise_clr[p] = req.write_data[gpiop_pkg::BITS_PER_PIN * (p % gpiop_pkg::PINS_PER_BANK)
                                     + gpiop_pkg::BIT_EDGE_RISE];
      end
    end
  end

  always_comb begin
    out_mask_nxt = out_mask_r;
    oe_mask_nxt = oe_mask_r;
    levels_nxt = levels_r;
    fall_nxt = fall_r;
    rise_nxt = rise_r;
    inte_nxt = inte_r;
    if (fire) begin
      unique case (req.kind)
        gpiop_pkg::KIND_WRITE: begin
          unique case (req.reg_select)
            gpiop_pkg::REG_OUT:      out_mask_nxt = wmask;
            gpiop_pkg::REG_OUT_SET:  out_mask_nxt = out_mask_r | wmask;
            gpiop_pkg::REG_OUT_CLR:  out_mask_nxt = out_mask_r & ~wmask;
            gpiop_pkg::REG_OUT_XOR:  out_mask_nxt = out_mask_r ^ wmask;
            gpiop_pkg::REG_OE:       oe_mask_nxt = wmask;
            gpiop_pkg::REG_OE_SET:   oe_mask_nxt = oe_mask_r | wmask;
            gpiop_pkg::REG_OE_CLR:   oe_mask_nxt = oe_mask_r & ~wmask;
            gpiop_pkg::REG_OE_XOR:   oe_mask_nxt = oe_mask_r ^ wmask;
            gpiop_pkg::REG_INTR: begin
              fall_nxt = fall_r & ~fall_clr;
              rise_nxt = rise_r & ~rise_clr;
            end
            gpiop_pkg::REG_INTE:     inte_nxt[req.bank_index] = req.write_data;
            gpiop_pkg::REG_INTE_SET:
              inte_nxt[req.bank_index] = inte_r[req.bank_index] | req.write_data;
            gpiop_pkg::REG_INTE_CLR:
              inte_nxt[req.bank_index] = inte_r[req.bank_index] & ~req.write_data;
            default: ;
          endcase
        end
        gpiop_pkg::KIND_SAMPLE: begin
          fall_nxt = fall_r | (levels_r & ~req.pin_levels);
          rise_nxt = rise_r | (~levels_r & req.pin_levels);
          levels_nxt = req.pin_levels & gpiop_pkg::PIN_MASK;
        end
        default: ;
      endcase
    end
  end

  assign raw_now = gpiop_pkg::raw_banks(levels_r, fall_r, rise_r);
  assign raw_nxt = gpiop_pkg::raw_banks(levels_nxt, fall_nxt, rise_nxt);

  always_comb begin
    read_data = '0;
    if (req.kind == gpiop_pkg::KIND_READ) begin
      unique case (req.reg_select)
        gpiop_pkg::REG_IN:   read_data = gpiop_pkg::WORD_W'(levels_r);
        gpiop_pkg::REG_OUT:  read_data = gpiop_pkg::WORD_W'(out_mask_r);
        gpiop_pkg::REG_OE:   read_data = gpiop_pkg::WORD_W'(oe_mask_r);
        gpiop_pkg::REG_INTR: read_data = raw_now[req.bank_index];
        gpiop_pkg::REG_INTE: read_data = inte_r[req.bank_index];
        gpiop_pkg::REG_INTS: read_data = raw_now[req.bank_index] & inte_r[req.bank_index];
        default:             read_data = '0;
      endcase
    end
  end

  always_comb begin
    for (int b = 0; b < gpiop_pkg::NUM_BANKS; b++) begin
      bank_hit[b] = |(raw_nxt[b] & inte_nxt[b]);
    end
  end

  assign rsp.read_data = read_data;
  assign rsp.pin_out = out_mask_nxt;
  assign rsp.pin_oe = oe_mask_nxt;
  assign rsp.irq = |bank_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_mask_r <= '0;
      oe_mask_r <= '0;
      levels_r <= '0;
      fall_r <= '0;
      rise_r <= '0;
      inte_r <= '0;
    end else begin
      out_mask_r <= out_mask_nxt;
      oe_mask_r <= oe_mask_nxt;
      levels_r <= levels_nxt;
      fall_r <= fall_nxt;
      rise_r <= rise_nxt;
      inte_r <= inte_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/gpio_port_with_pin_interrupts_core.sv -----
// GPIO port of 30 pins with set, clear and xor aliases for the output and
// output-enable masks and four interrupt bits per pin (level low, level high,
// falling edge, rising edge) in four banks of up to eight pins. Each request (a
// register read, a register write or a new pin sample) is captured in an input
// register, applied to the state as it moves on into a result register and
// answered from that result register. One request is accepted in every
// cycle while the result side keeps up. The result carries the read data, the
// output and output-enable masks after the request, and irq, which is high when
// any enabled interrupt bit is set.
`default_nettype none

module gpio_port_with_pin_interrupts_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [1:0]                     in_kind,
  input  wire logic [3:0]                     in_reg_select,
  input  wire logic [gpiop_pkg::BANK_W-1:0]   in_bank_index,
  input  wire logic [gpiop_pkg::WORD_W-1:0]   in_write_data,
  input  wire logic [gpiop_pkg::NUM_PINS-1:0] in_pin_levels,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [gpiop_pkg::WORD_W-1:0]        out_read_data,
  output logic [gpiop_pkg::NUM_PINS-1:0]      out_pin_out,
  output logic [gpiop_pkg::NUM_PINS-1:0]      out_pin_oe,
  output logic                                out_irq
);

  logic            req_valid_r, req_valid_nxt;
  gpiop_pkg::req_t req_r;
  logic            rsp_valid_r, rsp_valid_nxt;
  gpiop_pkg::rsp_t rsp_r;
  gpiop_pkg::rsp_t rsp;
  logic            load;
  logic            advance;

  assign advance = req_valid_r && (!rsp_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;
  assign load = in_valid && !in_stall;

  assign req_valid_nxt = load || (req_valid_r && !advance);
  assign rsp_valid_nxt = advance || (rsp_valid_r && out_stall);

  gpiop_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .req   (req_r),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      rsp_valid_r <= 1'b0;
    end else begin
      req_valid_r <= req_valid_nxt;
      rsp_valid_r <= rsp_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r.kind <= in_kind;
      req_r.reg_select <= in_reg_select;
      req_r.bank_index <= in_bank_index;
      req_r.write_data <= in_write_data;
      req_r.pin_levels <= in_pin_levels;
    end
    if (advance) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid = rsp_valid_r;
  assign out_read_data = rsp_r.read_data;
  assign out_pin_out = rsp_r.pin_out;
  assign out_pin_oe = rsp_r.pin_oe;
  assign out_irq = rsp_r.irq;

endmodule

`default_nettype wire

// ----- hw/rtl/gpiop_checker.sv -----
`default_nettype none

module gpiop_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [gpiop_pkg::WORD_W-1:0]   out_read_data,
  input wire logic [gpiop_pkg::NUM_PINS-1:0] out_pin_out,
  input wire logic [gpiop_pkg::NUM_PINS-1:0] out_pin_oe,
  input wire logic                           out_irq
);

  // The input side only backs up when a result is waiting and stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // A request that moves out of the input register shows up as a result.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !in_stall |=> out_valid)
    else $error("accepted request produced no result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_read_data)
      && $stable(out_pin_out) && $stable(out_pin_oe) && $stable(out_irq)))
    else $error("stalled result changed");

endmodule

bind gpio_port_with_pin_interrupts_core gpiop_checker u_gpiop_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_data (out_read_data),
  .out_pin_out   (out_pin_out),
  .out_pin_oe    (out_pin_oe),
  .out_irq       (out_irq)
);

`default_nettype wire

// ----- test/gpio_port_with_pin_interrupts_core_test.sv -----
`timescale 1ns / 100ps

module gpio_port_with_pin_interrupts_core_test;
  import gpiop_pkg::*;

  localparam logic [1:0] KIND_IDLE = 2'd3;
  localparam logic [3:0] REG_RESERVED_LO = 4'd14;
  localparam logic [3:0] REG_RESERVED_HI = 4'd15;
  localparam int RANDOM_REQUESTS = 900;
  localparam int QUIET_TAIL = 150;
  localparam int LONG_HOLD = 40;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    req_t req;
    logic fixed;
    rsp_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic [3:0] in_reg_select = '0;
  logic [BANK_W-1:0] in_bank_index = '0;
  logic [WORD_W-1:0] in_write_data = '0;
  logic [NUM_PINS-1:0] in_pin_levels = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [WORD_W-1:0] out_read_data;
  logic [NUM_PINS-1:0] out_pin_out;
  logic [NUM_PINS-1:0] out_pin_oe;
  logic out_irq;

  gpio_port_with_pin_interrupts_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_reg_select(in_reg_select),
    .in_bank_index(in_bank_index),
    .in_write_data(in_write_data),
    .in_pin_levels(in_pin_levels),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_read_data(out_read_data),
    .out_pin_out(out_pin_out),
    .out_pin_oe(out_pin_oe),
    .out_irq(out_irq)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the port state.
  logic [NUM_PINS-1:0] gp_out;
  logic [NUM_PINS-1:0] gp_oe;
  logic [NUM_PINS-1:0] gp_level;
  logic [NUM_PINS-1:0] gp_fall;
  logic [NUM_PINS-1:0] gp_rise;
  logic [WORD_W-1:0] gp_inte [NUM_BANKS];

  rsp_t due_responses[$];
  row_t plan[$];
  int mismatches = 0;
  int cycles = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;
  logic stall_next;
  logic quiet = 1'b0;
  rsp_t head;

  function automatic logic [WORD_W-1:0] raw_word(input int bank);
    logic [WORD_W-1:0] w;
    int pin;
    w = '0;
    for (int i = 0; i < PINS_PER_BANK; i++) begin
      pin = bank * PINS_PER_BANK + i;
      if (pin < NUM_PINS) begin
        w[BITS_PER_PIN * i +: BITS_PER_PIN] =
          {gp_rise[pin], gp_fall[pin], gp_level[pin], ~gp_level[pin]};
      end
    end
    return w;
  endfunction

  function automatic rsp_t port_step(input req_t r);
    rsp_t res;
    logic [NUM_PINS-1:0] m;
    int pin;
    res = '0;
    m = r.write_data[NUM_PINS-1:0];
    case (r.kind)
      KIND_READ: begin
        case (r.reg_select)
          REG_IN: res.read_data = WORD_W'(gp_level);
          REG_OUT: res.read_data = WORD_W'(gp_out);
          REG_OE: res.read_data = WORD_W'(gp_oe);
          REG_INTR: res.read_data = raw_word(r.bank_index);
          REG_INTE: res.read_data = gp_inte[r.bank_index];
          REG_INTS: res.read_data = raw_word(r.bank_index) & gp_inte[r.bank_index];
          default: res.read_data = '0;
        endcase
      end
      KIND_WRITE: begin
        case (r.reg_select)
          REG_OUT: gp_out = m;
          REG_OUT_SET: gp_out = gp_out | m;
          REG_OUT_CLR: gp_out = gp_out & ~m;
          REG_OUT_XOR: gp_out = gp_out ^ m;
          REG_OE: gp_oe = m;
          REG_OE_SET: gp_oe = gp_oe | m;
          REG_OE_CLR: gp_oe = gp_oe & ~m;
          REG_OE_XOR: gp_oe = gp_oe ^ m;
          REG_INTR: begin
            for (int i = 0; i < PINS_PER_BANK; i++) begin
              pin = r.bank_index * PINS_PER_BANK + i;
              if (pin < NUM_PINS) begin
                if (r.write_data[BITS_PER_PIN * i + BIT_EDGE_FALL]) gp_fall[pin] = 1'b0;
                if (r.write_data[BITS_PER_PIN * i + BIT_EDGE_RISE]) gp_rise[pin] = 1'b0;
              end
            end
          end
          REG_INTE: gp_inte[r.bank_index] = r.write_data;
          REG_INTE_SET: gp_inte[r.bank_index] = gp_inte[r.bank_index] | r.write_data;
          REG_INTE_CLR: gp_inte[r.bank_index] = gp_inte[r.bank_index] & ~r.write_data;
          default: ;
        endcase
      end
      KIND_SAMPLE: begin
        gp_fall = gp_fall | (gp_level & ~r.pin_levels);
        gp_rise = gp_rise | (~gp_level & r.pin_levels);
        gp_level = r.pin_levels;
      end
      default: ;
    endcase
    res.pin_out = gp_out;
    res.pin_oe = gp_oe;
    res.irq = 1'b0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      if ((raw_word(b) & gp_inte[b]) != '0) res.irq = 1'b1;
    end
    return res;
  endfunction

  task automatic add_row(input logic [1:0] kind, input logic [3:0] sel,
                         input logic [BANK_W-1:0] bank, input logic [WORD_W-1:0] data,
                         input logic [NUM_PINS-1:0] levels, input logic fixed = 1'b0,
                         input logic [WORD_W-1:0] rd = '0,
                         input logic [NUM_PINS-1:0] po = '0,
                         input logic [NUM_PINS-1:0] poe = '0);
    row_t row;
    row.req.kind = kind;
    row.req.reg_select = sel;
    row.req.bank_index = bank;
    row.req.write_data = data;
    row.req.pin_levels = levels;
    row.fixed = fixed;
    row.want.read_data = rd;
    row.want.pin_out = po;
    row.want.pin_oe = poe;
    row.want.irq = 1'b0;
    plan.push_back(row);
  endtask

  task automatic send_request(input req_t r, input logic fixed, input rsp_t want);
    rsp_t predicted;
    in_valid <= 1'b1;
    in_kind <= r.kind;
    in_reg_select <= r.reg_select;
    in_bank_index <= r.bank_index;
    in_write_data <= r.write_data;
    in_pin_levels <= r.pin_levels;
    do @(posedge clk); while (in_stall);
    predicted = port_step(r);
    due_responses.push_back(fixed ? want : predicted);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: checks every accepted response and stalls in random bursts,
  // with one long hold-off on demand from the request side.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_responses.size() == 0) begin
          $display("%0t: unexpected response, read_data %h", $time, out_read_data);
          mismatches++;
        end else begin
          head = due_responses.pop_front();
          if (out_read_data !== head.read_data) begin
            $display("%0t: read_data expected %h, got %h", $time, head.read_data,
                     out_read_data);
            mismatches++;
          end
          if (out_pin_out !== head.pin_out) begin
            $display("%0t: pin_out expected %h, got %h", $time, head.pin_out, out_pin_out);
            mismatches++;
          end
          if (out_pin_oe !== head.pin_oe) begin
            $display("%0t: pin_oe expected %h, got %h", $time, head.pin_oe, out_pin_oe);
            mismatches++;
          end
          if (out_irq !== head.irq) begin
            $display("%0t: irq expected %b, got %b", $time, head.irq, out_irq);
            mismatches++;
          end
        end
      end
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      stall_next = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        stall_next = 1'b1;
      end
      out_stall <= stall_next;
    end
  end

  initial begin
    req_t r;
    rsp_t none;
    int pick;
    none = '0;
    gp_out = '0;
    gp_oe = '0;
    gp_level = '0;
    gp_fall = '0;
    gp_rise = '0;
    for (int b = 0; b < NUM_BANKS; b++) gp_inte[b] = '0;

    add_row(KIND_READ, REG_IN, 0, 32'h0, '0, 1'b1);
    add_row(KIND_READ, REG_INTR, 0, 32'h0, '0, 1'b1, 32'h1111_1111);
    add_row(KIND_READ, REG_INTR, 3, 32'h0, '0, 1'b1, 32'h0011_1111);
    add_row(KIND_WRITE, REG_OUT, 0, 32'hFFFF_FFFF, '0, 1'b1, '0, PIN_MASK);
    add_row(KIND_WRITE, REG_OE, 0, 32'hFFFF_FFFF, '0, 1'b1, '0, PIN_MASK, PIN_MASK);
    add_row(KIND_READ, REG_OUT_SET, 0, 32'h0, '0, 1'b1, '0, PIN_MASK, PIN_MASK);
    add_row(KIND_READ, REG_OUT, 0, 32'h0, '0, 1'b1, WORD_W'(PIN_MASK), PIN_MASK, PIN_MASK);
    add_row(KIND_WRITE, REG_OUT_CLR, 0, 32'h0000_FFFF, '0);
    add_row(KIND_WRITE, REG_OUT_XOR, 0, 32'hAAAA_AAAA, '0);
    add_row(KIND_WRITE, REG_OUT_SET, 0, 32'h0000_0005, '0);
    add_row(KIND_WRITE, REG_OE_CLR, 0, 32'hFFFF_0000, '0);
    add_row(KIND_WRITE, REG_OE_SET, 0, 32'h0001_0000, '0);
    add_row(KIND_WRITE, REG_OE_XOR, 0, 32'h5555_5555, '0);
    add_row(KIND_SAMPLE, REG_IN, 0, 32'h0, PIN_MASK);
    add_row(KIND_SAMPLE, REG_IN, 0, 32'h0, '0);
    add_row(KIND_WRITE, REG_INTE, 0, 32'h8888_8888, '0);
    add_row(KIND_READ, REG_INTS, 0, 32'h0, '0);
    add_row(KIND_WRITE, REG_INTR, 0, 32'hFFFF_FFFF, '0);
    add_row(KIND_READ, REG_INTR, 0, 32'h0, '0);
    add_row(KIND_WRITE, REG_INTE_SET, 3, 32'hFF11_1111, '0);
    add_row(KIND_WRITE, REG_INTE_CLR, 3, 32'h0011_1111, '0);
    add_row(KIND_WRITE, REG_IN, 0, 32'hFFFF_FFFF, '0);
    add_row(KIND_WRITE, REG_INTS, 3, 32'hFFFF_FFFF, '0);
    add_row(KIND_READ, REG_RESERVED_LO, 1, 32'h0, '0);
    add_row(KIND_WRITE, REG_RESERVED_HI, 2, 32'hFFFF_FFFF, '0);
    add_row(KIND_IDLE, REG_INTE, 3, 32'hFFFF_FFFF, PIN_MASK);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) send_request(plan[i].req, plan[i].fixed, plan[i].want);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == 300) hold_requests <= hold_requests + 1;
      if (n == 500) begin
        in_valid <= 1'b0;
        while (due_responses.size() != 0) @(posedge clk);
      end
      if (n == RANDOM_REQUESTS - QUIET_TAIL) quiet <= 1'b1;

      pick = $urandom_range(0, 99);
      r.kind = pick < 30 ? KIND_READ : pick < 70 ? KIND_WRITE :
               pick < 95 ? KIND_SAMPLE : KIND_IDLE;
      r.reg_select = $urandom_range(0, 99) < 4 ? 4'($urandom_range(14, 15))
                                              : 4'($urandom_range(0, 13));
      r.bank_index = BANK_W'($urandom_range(0, NUM_BANKS - 1));
      case ($urandom_range(0, 5))
        0: r.write_data = 32'hFFFF_FFFF;
        1: r.write_data = 32'h0;
        2: r.write_data = 32'h1 << $urandom_range(0, 31);
        default: r.write_data = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0: r.pin_levels = NUM_PINS'($urandom);
        1: r.pin_levels = gp_level ^ (NUM_PINS'(1) << $urandom_range(0, NUM_PINS - 1));
        2: r.pin_levels = gp_level ^ NUM_PINS'($urandom & $urandom);
        3: r.pin_levels = $urandom_range(0, 1) ? PIN_MASK : '0;
        default: r.pin_levels = NUM_PINS'($urandom);
      endcase
      send_request(r, 1'b0, none);

      if (!quiet && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end

    in_valid <= 1'b0;
    while (due_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && due_responses.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
